FILE: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Sizes, operation and status codes, controller state and command bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;
    localparam int OP_W       = 2;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

endpackage

FILE: src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: deque controller
// Two-state sequencer: take an item, then load the result register.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.load  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath: deque datapath
// Head index, entry count, ring addressing, slot RAM and result register.
// ----------------------------------------------------------------------------
module dq_dpath
    import dq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [VAL_W-1:0] i_value,
    output logic signed [VAL_W-1:0] o_popped,
    output logic [ST_W-1:0]         o_status,
    output logic                    o_now_empty,
    output logic                    o_now_full
);

    t_op              op;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pop_ok;
    t_status          r_status, status;
    logic             is_push, err_full, err_empty;
    logic [IDX_W-1:0] head_dec, head_inc, rear_pos, addr;
    logic [CNT_W-1:0] off;
    logic [SUM_W-1:0] sum;
    logic             we;
    logic [DATA_WIDTH-1:0] rdata;

    logic signed [VAL_W-1:0] r_popped;
    logic [ST_W-1:0]         r_st_out;
    logic                    r_now_empty, r_now_full;

    assign op        = t_op'(i_op);
    assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
    assign err_full  = is_push && (r_count == CNT_W'(DEPTH));
    assign err_empty = !is_push && (r_count == '0);

    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign off      = (op == OP_POP_REAR) ? r_count - 1'b1 : r_count;
    assign sum      = SUM_W'(r_head) + SUM_W'(off);
    assign rear_pos = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);

    always_comb begin
        unique case (op)
            OP_PUSH_FRONT: addr = head_dec;
            OP_POP_FRONT:  addr = r_head;
            OP_PUSH_REAR,
            OP_POP_REAR:   addr = rear_pos;
            default:       addr = r_head;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        status  = ST_DONE;
        if (err_full) begin
            status = ST_FULL;
        end else if (err_empty) begin
            status = ST_EMPTY;
        end else if (i_cmd.accept) begin
            if (is_push) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
            if (op == OP_PUSH_FRONT) begin
                n_head = head_dec;
            end else if (op == OP_POP_FRONT) begin
                n_head = head_inc;
            end
        end
    end

    assign we = i_cmd.accept && is_push && !err_full;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (DATA_WIDTH'($unsigned(i_value))),
        .i_re    (i_cmd.accept),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pop_ok <= !is_push && !err_empty;
            r_status <= status;
        end
        if (i_cmd.load) begin
            r_popped    <= r_pop_ok ? VAL_W'(rdata) : '0;
            r_st_out    <= r_status;
            r_now_empty <= (r_count == '0);
            r_now_full  <= (r_count == CNT_W'(DEPTH));
        end
    end

    assign o_popped    = r_popped;
    assign o_status    = r_st_out;
    assign o_now_empty = r_now_empty;
    assign o_now_full  = r_now_full;

endmodule

FILE: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a ring of slots
// Push or pop at either end; one result per request.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  request  | i_in_valid / o_in_ready   | i_op, i_value
//  result   | o_out_valid / i_out_ready | o_popped, o_status, o_now_empty, o_now_full
//
// Requests are taken one at a time: in S_IDLE the accept addresses the slot RAM,
// and in S_FINISH the registered RAM read is loaded into the result register.
// A request is taken while the previous result waits only if that result
// is taken at the same edge.
// Synchronous active-low reset empties the deque; slot contents are not cleared.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_popped,
    output logic [ST_W-1:0]         o_status,
    output logic                    o_now_empty,
    output logic                    o_now_full
);

    t_cmd cmd;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_popped    (o_popped),
        .o_status    (o_status),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

endmodule

FILE: src/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the deque
// Result consistency and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [VAL_W-1:0] o_popped,
    input logic [ST_W-1:0]         o_status,
    input logic                    o_now_empty,
    input logic                    o_now_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before taken");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while one is in flight");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_now_empty && o_now_full))
        else $error("empty and full together");

    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_FULL || o_now_full)
                     && (o_status != ST_EMPTY || o_now_empty))
        else $error("error status disagrees with fill flags");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_popped == '0)
        else $error("nonzero value on error");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_popped    (o_popped),
    .o_status    (o_status),
    .o_now_empty (o_now_empty),
    .o_now_full  (o_now_full)
);
